// ===== rtl/adcss_pkg.sv =====
// adcss_pkg: shared types, constants and helper functions for the ADC reading
// seven-segment display block. No dependencies; imported by every RTL module.
`timescale 1ns / 1ps
`default_nettype none

package adcss_pkg;

   // Display geometry
   localparam int DIGIT_COUNT = 4;
   localparam int POS_W       = $clog2(DIGIT_COUNT);

   // Field widths
   localparam int SAMPLE_W = 10;
   localparam int TICK_W   = 16;
   localparam int ENABLE_W = 4;
   localparam int SEG_W    = 7;
   localparam int DIGIT_W  = 4;
   localparam int VALUE_W  = 13;

   // Millivolt scaling: mv = sample * 5000 >> 10
   localparam int MV_SHIFT = 10;
   localparam int PROD_W   = SAMPLE_W + VALUE_W;
   localparam logic [PROD_W-1:0] MV_SCALE = PROD_W'(5000);

   // Reset values of the timing registers
   localparam logic [TICK_W-1:0] BLANK_RESET = 16'd1;
   localparam logic [TICK_W-1:0] DWELL_RESET = 16'd500;

   // Register indexes of the configuration port
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLANK_TICKS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DWELL_TICKS = 1'b1;

   // Fixed patterns shown by the unfinished timer modes, and the thousands digit enable
   localparam logic [ENABLE_W-1:0] ENABLE_TIMER_UP   = 4'b0010;
   localparam logic [ENABLE_W-1:0] ENABLE_TIMER_DOWN = 4'b0001;
   localparam logic [ENABLE_W-1:0] ENABLE_THOUSANDS  = 4'b1000;
   localparam logic [SEG_W-1:0]    SEG_ONE           = 7'h06;

   // Mode code = white_button * 2 + yellow_button
   typedef enum logic [1:0] {
      MODE_VOLTS = 2'd0,
      MODE_RAW   = 2'd1,
      MODE_UP    = 2'd2,
      MODE_DOWN  = 2'd3
   } mode_type;

   // Word held in the input register
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [VALUE_W-1:0]  millivolts;
      mode_type            mode;
   } front_word_type;

   // Timing registers handed to the sequencer
   typedef struct packed {
      logic [TICK_W-1:0] blank_ticks;
      logic [TICK_W-1:0] dwell_ticks;
   } tick_cfg_type;

   // Segments g..a for a decimal digit, bit0 is segment a
   function automatic logic [SEG_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
      logic [SEG_W-1:0] code;
      unique case (digit)
         4'd0:    code = 7'h3F;
         4'd1:    code = 7'h06;
         4'd2:    code = 7'h5B;
         4'd3:    code = 7'h4F;
         4'd4:    code = 7'h66;
         4'd5:    code = 7'h6D;
         4'd6:    code = 7'h7D;
         4'd7:    code = 7'h07;
         4'd8:    code = 7'h7F;
         4'd9:    code = 7'h6F;
         default: code = '0;
      endcase
      return code;
   endfunction

   // Largest k in 0..9 with value >= k * scale (parallel compares, full width)
   function automatic logic [DIGIT_W-1:0] lead_digit(input logic [VALUE_W-1:0] value,
                                                     input int unsigned scale);
      logic [DIGIT_W-1:0] digit;
      digit = '0;
      for (int k = 1; k < 10; k++) begin
         if (32'(value) >= k * scale) digit = DIGIT_W'(k);
      end
      return digit;
   endfunction

   // Decimal split, thousands in [15:12] down to units in [3:0]
   function automatic logic [DIGIT_COUNT*DIGIT_W-1:0] split_digits(
      input logic [VALUE_W-1:0] value);
      logic [DIGIT_W-1:0] thou;
      logic [DIGIT_W-1:0] hund;
      logic [DIGIT_W-1:0] tens;
      logic [VALUE_W-1:0] rest;
      thou = lead_digit(value, 1000);
      rest = value - VALUE_W'(thou) * VALUE_W'(1000);
      hund = lead_digit(rest, 100);
      rest = rest - VALUE_W'(hund) * VALUE_W'(100);
      tens = lead_digit(rest, 10);
      rest = rest - VALUE_W'(tens) * VALUE_W'(10);
      return {thou, hund, tens, rest[DIGIT_W-1:0]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/adcss_req_if.sv =====
// adcss_req_if: valid/ready channel carrying one display tick word
// (converter sample and button levels). Depends on adcss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface adcss_req_if
   import adcss_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] adc_sample;
   logic                white_button;
   logic                yellow_button;

   modport source (output valid, adc_sample, white_button, yellow_button, input ready);
   modport sink   (input valid, adc_sample, white_button, yellow_button, output ready);
endinterface

`default_nettype wire

// ===== rtl/adcss_rsp_if.sv =====
// adcss_rsp_if: valid/ready channel carrying one display drive word
// (digit enables and segment code). Depends on adcss_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface adcss_rsp_if
   import adcss_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ENABLE_W-1:0] digit_enable;
   logic [SEG_W-1:0]    segment_code;

   modport source (output valid, digit_enable, segment_code, input ready);
   modport sink   (input valid, digit_enable, segment_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/adcss_front.sv =====
// adcss_front: input register stage; scales the sample to millivolts and
// encodes the button mode. Depends on adcss_pkg and adcss_req_if.
`timescale 1ns / 1ps
`default_nettype none

module adcss_front
   import adcss_pkg::*;
   (
   input  wire logic           clock,
   input  wire logic           reset,
   adcss_req_if.sink           req_bus,
   output logic                s1_valid,
   input  wire logic           s1_ready,
   output front_word_type      s1_word
   );

   logic           valid_ff;
   front_word_type word_ff;
   front_word_type word_in;
   logic [PROD_W-1:0] product;
   logic           req_fire;

   // Stage takes a word when empty or when it is moving on
   assign req_bus.ready = !valid_ff || s1_ready;
   assign req_fire      = req_bus.valid && req_bus.ready;

   // Millivolts = sample * 5000 >> 10, exact truncation
   always_comb begin
      product            = PROD_W'(req_bus.adc_sample) * MV_SCALE;
      word_in.sample     = req_bus.adc_sample;
      word_in.millivolts = product[MV_SHIFT +: VALUE_W];
      word_in.mode       = mode_type'({req_bus.white_button, req_bus.yellow_button});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_fire) begin
         valid_ff <= 1'b1;
      end else if (s1_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         word_ff <= word_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_word  = word_ff;

   // A held word must not change while the sequencer is stalled
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(valid_ff) && !$past(s1_ready)) |->
         (valid_ff && word_ff == $past(word_ff)))
      else $error("input stage word changed while stalled");

endmodule

`default_nettype wire

// ===== rtl/adcss_mux.sv =====
// adcss_mux: frame capture, digit split, blank/dwell sequencing and the
// result register. Depends on adcss_pkg and adcss_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module adcss_mux
   import adcss_pkg::*;
   (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           s1_valid,
   output logic                s1_ready,
   input  wire front_word_type s1_word,
   input  wire tick_cfg_type   tick_cfg,
   adcss_rsp_if.source         rsp_bus
   );

   // Sequencer state
   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic               blank_ff, blank_in;
   logic [TICK_W-1:0]  count_ff, count_in;
   mode_type           mode_ff,  mode_in;
   logic [DIGIT_W-1:0] digits_ff [DIGIT_COUNT];
   logic [DIGIT_COUNT*DIGIT_W-1:0] split_in;

   // Result register
   logic                rsp_valid_ff;
   logic [ENABLE_W-1:0] enable_ff, enable_in;
   logic [SEG_W-1:0]    segment_ff, segment_in;

   logic              fire;
   logic              frame_start;
   logic              capture;
   logic [TICK_W-1:0] limit;
   logic [TICK_W:0]   count_next;

   assign s1_ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire     = s1_valid && s1_ready;

   assign frame_start = (pos_ff == '0) && blank_ff && (count_ff == '0);
   assign capture     = fire && frame_start;

   // Value chosen for this frame, split into decimal digits
   always_comb begin
      if (s1_word.mode == MODE_VOLTS) begin
         split_in = split_digits(s1_word.millivolts);
      end else begin
         split_in = split_digits(VALUE_W'(s1_word.sample));
      end
   end

   // One tick: drive word and next sequencer state
   always_comb begin
      mode_in    = frame_start ? s1_word.mode : mode_ff;
      pos_in     = pos_ff;
      blank_in   = blank_ff;
      count_in   = count_ff;
      limit      = blank_ff ? tick_cfg.blank_ticks : tick_cfg.dwell_ticks;
      count_next = {1'b0, count_ff} + 1'b1;
      if (mode_in == MODE_UP || mode_in == MODE_DOWN) begin
         // timer modes: fixed '1', frame does not advance
         enable_in  = (mode_in == MODE_UP) ? ENABLE_TIMER_UP : ENABLE_TIMER_DOWN;
         segment_in = SEG_ONE;
      end else begin
         if (blank_ff) begin
            enable_in  = '0;
            segment_in = '0;
         end else begin
            enable_in  = ENABLE_THOUSANDS >> pos_ff;
            segment_in = seg_code(digits_ff[pos_ff]);
         end
         // a zero limit or a wrapped count ends the phase, as does a lowered limit
         if (count_next >= {1'b0, limit}) begin
            count_in = '0;
            blank_in = !blank_ff;
            if (!blank_ff) pos_in = pos_ff + 1'b1;
         end else begin
            count_in = count_next[TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         blank_ff     <= 1'b1;
         count_ff     <= '0;
         mode_ff      <= MODE_VOLTS;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < DIGIT_COUNT; i++) digits_ff[i] <= '0;
      end else begin
         if (fire) begin
            pos_ff   <= pos_in;
            blank_ff <= blank_in;
            count_ff <= count_in;
            mode_ff  <= mode_in;
         end
         if (capture && (s1_word.mode == MODE_VOLTS || s1_word.mode == MODE_RAW)) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               digits_ff[i] <= split_in[(DIGIT_COUNT-1-i)*DIGIT_W +: DIGIT_W];
            end
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         enable_ff  <= enable_in;
         segment_ff <= segment_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.digit_enable = enable_ff;
   assign rsp_bus.segment_code = segment_ff;

   // At most one digit lit at a time
   a_enable_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(enable_ff))
      else $error("more than one digit enabled");

   // Blanked word carries no segments
   a_blank_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && enable_ff == '0) |-> (segment_ff == '0))
      else $error("segments lit while all digits blanked");

   // Timer modes park the sequencer at frame start
   a_timer_parked: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_UP || mode_ff == MODE_DOWN) |-> frame_start)
      else $error("timer mode away from frame start");

endmodule

`default_nettype wire

// ===== rtl/adc_reading_to_multiplexed_seven_segment.sv =====
// An accepted word goes from req_bus through the input and result registers to rsp_bus.
// Throughput: one tick word per cycle while rsp_bus is ready; each register holds a word.
// Display sequence (blank, then dwell, per digit): one step per accepted word in volts/raw.
// Reset (synchronous, active high) empties both stages, sets blanking before the thousands
// digit, clears the digits, selects volts mode, blank_ticks = 1 and dwell_ticks = 500.
// Depends on adcss_pkg, adcss_req_if, adcss_rsp_if, adcss_front and adcss_mux.
`timescale 1ns / 1ps
`default_nettype none

module adc_reading_to_multiplexed_seven_segment
   import adcss_pkg::*;
   (
   input  wire logic                   clock,
   input  wire logic                   reset,
   adcss_req_if.sink                   req_bus,
   adcss_rsp_if.source                 rsp_bus,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]      csr_write_data
   );

   logic [TICK_W-1:0] blank_ticks_ff;
   logic [TICK_W-1:0] dwell_ticks_ff;
   tick_cfg_type      tick_cfg;
   logic              s1_valid;
   logic              s1_ready;
   front_word_type    s1_word;

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blank_ticks_ff <= BLANK_RESET;
         dwell_ticks_ff <= DWELL_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLANK_TICKS: blank_ticks_ff <= csr_write_data;
            CSR_DWELL_TICKS: dwell_ticks_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign tick_cfg.blank_ticks = blank_ticks_ff;
   assign tick_cfg.dwell_ticks = dwell_ticks_ff;

   adcss_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_word  (s1_word)
   );

   adcss_mux u_mux (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_ready (s1_ready),
      .s1_word  (s1_word),
      .tick_cfg (tick_cfg),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== tb/sv/adcss_display_checker.sv =====
// adcss_display_checker: watches the tick and display channels and the timing
// register port, predicts each display word and compares it with the one seen.
// Depends on adcss_pkg, adcss_req_if and adcss_rsp_if.
`timescale 1ns / 1ps

module adcss_display_checker
   import adcss_pkg::*;
   (
   input  wire logic                   clock,
   input  wire logic                   reset,
   adcss_req_if                        req_mon,
   adcss_rsp_if                        rsp_mon,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [TICK_W-1:0]      csr_write_data,
   output int                          mismatches,
   output int                          outstanding
   );

   // Segments g..a per decimal digit, digit 0 in the low bits
   localparam logic [10*SEG_W-1:0] GLYPHS = {
      7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
   };

   typedef struct packed {
      logic [ENABLE_W-1:0] enable;
      logic [SEG_W-1:0]    segs;
   } drive_word_type;

   // Words still owed by the block, oldest first
   drive_word_type drive_q[$];

   // Own copy of the display sequencer
   logic [TICK_W-1:0]  blank_len;
   logic [TICK_W-1:0]  dwell_len;
   logic [POS_W-1:0]   position;
   logic               blanking;
   logic [TICK_W-1:0]  tick_count;
   logic [DIGIT_W-1:0] shown [DIGIT_COUNT];
   mode_type           shown_mode;
   int                 err_count;

   // Thousands in shown[0] down to units in shown[3]
   function automatic void load_digits(input int value);
      shown[0] = DIGIT_W'((value / 1000) % 10);
      shown[1] = DIGIT_W'((value % 1000) / 100);
      shown[2] = DIGIT_W'((value % 100) / 10);
      shown[3] = DIGIT_W'(value % 10);
   endfunction

   // One tick: latch at frame start, emit the word, then advance the phase unless in a timer mode
   function automatic drive_word_type next_drive_word(input logic [SAMPLE_W-1:0] sample,
                                                      input logic white,
                                                      input logic yellow);
      drive_word_type word;
      logic [TICK_W-1:0] span;
      if (position == 0 && blanking && tick_count == 0) begin
         shown_mode = mode_type'({white, yellow});
         if (shown_mode == MODE_VOLTS)
            load_digits((int'(sample) * 5000) >> MV_SHIFT);
         else if (shown_mode == MODE_RAW)
            load_digits(int'(sample));
      end
      // timer modes hold the frame at its start
      if (shown_mode == MODE_UP || shown_mode == MODE_DOWN) begin
         word.enable = (shown_mode == MODE_UP) ? ENABLE_TIMER_UP : ENABLE_TIMER_DOWN;
         word.segs   = SEG_ONE;
         return word;
      end
      if (blanking) begin
         word = '0;
         span = blank_len;
      end else begin
         word.enable = ENABLE_THOUSANDS >> position;
         word.segs   = GLYPHS[shown[position]*SEG_W +: SEG_W];
         span        = dwell_len;
      end
      // a length of zero ends the phase at once, as does a shortened one
      tick_count = tick_count + 1'b1;
      if (tick_count >= span || tick_count == 0) begin
         tick_count = '0;
         if (blanking) begin
            blanking = 1'b0;
         end else begin
            blanking = 1'b1;
            position = position + 1'b1;
         end
      end
      return word;
   endfunction

   // Compare, predict and track register writes on each edge
   always @(posedge clock) begin : track
      drive_word_type want;
      drive_word_type got;
      if (reset) begin
         blank_len  = BLANK_RESET;
         dwell_len  = DWELL_RESET;
         position   = '0;
         blanking   = 1'b1;
         tick_count = '0;
         shown_mode = MODE_VOLTS;
         for (int i = 0; i < DIGIT_COUNT; i++) shown[i] = '0;
         drive_q.delete();
         err_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.enable = rsp_mon.digit_enable;
            got.segs   = rsp_mon.segment_code;
            if (drive_q.size() == 0) begin
               $display("%0t: unexpected word: expected none, got enable %b segments %h",
                        $time, got.enable, got.segs);
               err_count++;
            end else begin
               want = drive_q.pop_front();
               if (got.enable !== want.enable)
                  $display("%0t: digit_enable: expected %b, got %b",
                           $time, want.enable, got.enable);
               if (got.segs !== want.segs)
                  $display("%0t: segment_code: expected %h, got %h",
                           $time, want.segs, got.segs);
               if (got !== want) err_count++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            drive_q.push_back(next_drive_word(req_mon.adc_sample, req_mon.white_button,
                                              req_mon.yellow_button));
         if (csr_write_enable) begin
            if (csr_index == CSR_BLANK_TICKS) blank_len = csr_write_data;
            else if (csr_index == CSR_DWELL_TICKS) dwell_len = csr_write_data;
         end
      end
      mismatches  <= err_count;
      outstanding <= drive_q.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: drives tick words and timing register writes into the display block,
// with random gaps on both channels. Depends on adcss_pkg, both channel
// interfaces, the block itself and adcss_display_checker.
`timescale 1ns / 1ps

module testbench;
   import adcss_pkg::*;

   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 600000;

   typedef enum int {TWIST_NONE, TWIST_HOLD, TWIST_PAUSE} twist_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [TICK_W-1:0]      csr_write_data;
   int                     mismatches;
   int                     outstanding;
   int                     cycles = 0;
   bit                     calm = 1'b0;
   bit                     hold_request = 1'b0;

   adcss_req_if req_bus ();
   adcss_rsp_if rsp_bus ();

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   adc_reading_to_multiplexed_seven_segment uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   adcss_display_checker display_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   // Mostly short gaps, now and then a long one; none in a calm stretch
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Offer one tick word and hold it until taken
   task automatic send_tick(input logic [SAMPLE_W-1:0] sample, input logic white,
                            input logic yellow);
      int gap;
      req_bus.valid         <= 1'b1;
      req_bus.adc_sample    <= sample;
      req_bus.white_button  <= white;
      req_bus.yellow_button <= yellow;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every owed display word
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic set_timing(input logic [TICK_W-1:0] blank, input logic [TICK_W-1:0] dwell);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BLANK_TICKS;
      csr_write_data   <= blank;
      @(posedge clock);
      csr_index        <= CSR_DWELL_TICKS;
      csr_write_data   <= dwell;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // One timing setting, then random ticks, mostly in converter modes
   task automatic run_phase(input logic [TICK_W-1:0] blank, input logic [TICK_W-1:0] dwell,
                            input int count, input twist_type twist);
      int r;
      logic [SAMPLE_W-1:0] sample;
      drain();
      set_timing(blank, dwell);
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            if (twist == TWIST_HOLD) hold_request = 1'b1;
            else if (twist == TWIST_PAUSE) drain();
         end
         r = $urandom_range(0, 9);
         if (r == 0) sample = '0;
         else if (r == 1) sample = '1;
         else sample = SAMPLE_W'($urandom_range(0, 1023));
         send_tick(sample, $urandom_range(0, 9) < 2, 1'($urandom_range(0, 1)));
      end
   endtask

   // Display side: random stalls, and one long hold-off on request
   initial begin : receiver
      int stall;
      rsp_bus.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = pick_gap();
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin : stimulus
      req_bus.valid         = 1'b0;
      req_bus.adc_sample    = '0;
      req_bus.white_button  = 1'b0;
      req_bus.yellow_button = 1'b0;
      csr_write_enable      = 1'b0;
      csr_index             = CSR_BLANK_TICKS;
      csr_write_data        = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing: full scale in volts, thousands digit part way through its dwell
      repeat (4) send_tick(10'd1023, 1'b0, 1'b0);
      drain();
      // zero blank acts as one; shortened dwell ends the running phase at once
      set_timing(16'd0, 16'd1);
      repeat (7) send_tick(10'd1023, 1'b0, 1'b0);
      // each later frame starts on a multiple of eight ticks from here
      repeat (8) send_tick(10'd1023, 1'b0, 1'b1);
      repeat (8) send_tick(10'd0, 1'b0, 1'b0);
      send_tick(10'd0, 1'b1, 1'b0);
      send_tick(10'd1023, 1'b1, 1'b1);
      send_tick(10'd512, 1'b0, 1'b0);

      run_phase(16'd1, 16'd1, 150, TWIST_NONE);
      run_phase(16'd2, 16'd3, 150, TWIST_HOLD);
      run_phase(16'd65535, 16'd65535, 25, TWIST_NONE);
      run_phase(16'd1, 16'd4, 150, TWIST_PAUSE);
      run_phase(16'd1, 16'd65535, 25, TWIST_NONE);
      run_phase(16'd3, 16'd1, 150, TWIST_NONE);
      run_phase(16'd0, 16'd0, 100, TWIST_HOLD);
      run_phase(16'd5, 16'd2, 150, TWIST_NONE);
      run_phase(16'd1, 16'd2, 150, TWIST_PAUSE);
      run_phase(16'd2, 16'd2, 100, TWIST_NONE);

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) $display("testbench: clean");
      else $display("testbench: errors");
      $finish;
   end

endmodule
